// File: hdl/ttyld_pkg.sv
// Shared types, constants and helpers of the canonical line discipline.
package ttyld_pkg;

  // Character constants used by input and output mapping.
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h00;
  localparam logic [7:0] STRIP_MASK  = 8'h7F;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_SIGNAL = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_ACK    = 2'd3;

  // Signal codes.
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;
  localparam logic [1:0] SIG_SUSP = 2'd3;

  // Input item modes.
  localparam logic MODE_CHAR = 1'b0;

  // Configuration register indexes.
  localparam logic [2:0] REG_INPUT_MODES  = 3'd0;
  localparam logic [2:0] REG_LOCAL_MODES  = 3'd1;
  localparam logic [2:0] REG_OUTPUT_MODES = 3'd2;
  localparam logic [2:0] REG_SIGNAL_CHARS = 3'd3;
  localparam logic [2:0] REG_EDIT_CHARS   = 3'd4;
  localparam logic [2:0] REG_EOF_CHAR     = 3'd5;

  // Configuration register reset values.
  localparam logic [4:0]  RST_INPUT_MODES  = 5'd8;
  localparam logic [2:0]  RST_LOCAL_MODES  = 3'd7;
  localparam logic [2:0]  RST_OUTPUT_MODES = 3'd1;
  localparam logic [23:0] RST_SIGNAL_CHARS = 24'h1A1C03;
  localparam logic [23:0] RST_EDIT_CHARS   = 24'h17157F;
  localparam logic [7:0]  RST_EOF_CHAR     = 8'd4;

  typedef struct packed {
    logic        mode;
    logic [7:0]  rx_char;
    logic [6:0]  read_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  signal_code;
    logic        held;
    logic        drained;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  input_modes;
    logic [2:0]  local_modes;
    logic [2:0]  output_modes;
    logic [23:0] signal_chars;
    logic [23:0] edit_chars;
    logic [7:0]  eof_key;
  } cfg_t;

  // Commands passed from the classifier to the executor.
  typedef enum logic [2:0] {
    CMD_ACK,
    CMD_SIG,
    CMD_EDIT,
    CMD_APPEND,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  ch;
    logic [1:0]  sig;
    logic [6:0]  count;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ECHO2,
    B_RD_ADDR,
    B_RD_OUT
  } back_state_t;

  // Builds one result word.
  function automatic out_item_t mk_result(logic [1:0] kind, logic [7:0] byte_v,
                                          logic [1:0] sig, logic held,
                                          logic drained, logic last);
    out_item_t r;
    r.out_kind    = kind;
    r.out_byte    = byte_v;
    r.signal_code = sig;
    r.held        = held;
    r.drained     = drained;
    r.last        = last;
    return r;
  endfunction

endpackage

// File: hdl/canonical_tty_line_discipline_core.sv
// Top level of the canonical line discipline: register port, classifier, queue and executor.
//
//   channel | handshake                  | word
//   in      | in_valid / in_ready        | in_data (mode, rx_char, read_count)
//   out     | out_valid / out_ready      | out_data (kind, byte, signal, flags)
//   cfg     | psel, penable, pwrite      | paddr, pwdata, prdata; pready tied high
//
// An accepted word is classified in the cycle it arrives and enters a two-entry queue.
// The executor gives one or two result words for a character, and for a read that pops N
// bytes it passes a decode step, a ring memory address step, then a byte a cycle while the
// result register is not stalled.
// A stalled result register holds the executor; the queue keeps taking words until full.
// Reset clears the indices, the line flag and the registers; ring contents stay undefined.
module canonical_tty_line_discipline_core #(
  parameter int RING_DEPTH = 4096,
  parameter int MAX_READ   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttyld_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttyld_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ttyld_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  cmd_t       front_cmd;
  cmd_t       q_cmd;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_modes  <= RST_INPUT_MODES;
      cfg_r.local_modes  <= RST_LOCAL_MODES;
      cfg_r.output_modes <= RST_OUTPUT_MODES;
      cfg_r.signal_chars <= RST_SIGNAL_CHARS;
      cfg_r.edit_chars   <= RST_EDIT_CHARS;
      cfg_r.eof_key      <= RST_EOF_CHAR;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INPUT_MODES:  cfg_r.input_modes  <= pwdata[4:0];
        REG_LOCAL_MODES:  cfg_r.local_modes  <= pwdata[2:0];
        REG_OUTPUT_MODES: cfg_r.output_modes <= pwdata[2:0];
        REG_SIGNAL_CHARS: cfg_r.signal_chars <= pwdata[23:0];
        REG_EDIT_CHARS:   cfg_r.edit_chars   <= pwdata[23:0];
        REG_EOF_CHAR:     cfg_r.eof_key      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_INPUT_MODES:  prdata = {27'd0, cfg_r.input_modes};
      REG_LOCAL_MODES:  prdata = {29'd0, cfg_r.local_modes};
      REG_OUTPUT_MODES: prdata = {29'd0, cfg_r.output_modes};
      REG_SIGNAL_CHARS: prdata = {8'd0, cfg_r.signal_chars};
      REG_EDIT_CHARS:   prdata = {8'd0, cfg_r.edit_chars};
      REG_EOF_CHAR:     prdata = {24'd0, cfg_r.eof_key};
      default:          prdata = 32'd0;
    endcase
  end

  assign in_ready = !q_full;

  ttyld_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .in_item(in_data),
    .cfg    (cfg_r),
    .cmd    (front_cmd)
  );

  ttyld_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && in_ready),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head_cmd (q_cmd)
  );

  ttyld_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(q_valid),
    .cmd      (q_cmd),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: hdl/ttyld_front.sv
// Front end: input mapping, signal detection and edit classification of one word.
module ttyld_front #(
  parameter int MAX_READ = 64
) (
  input  ttyld_pkg::in_item_t in_item,
  input  ttyld_pkg::cfg_t     cfg,
  output ttyld_pkg::cmd_t     cmd
);
  import ttyld_pkg::*;

  localparam logic [6:0] MaxReadC = 7'(MAX_READ);

  logic [7:0] ch_strip;
  logic [7:0] ch_low;
  logic [7:0] ch_map;
  logic       cr_drop;
  logic [7:0] erase_c;
  logic [7:0] kill_c;
  logic [7:0] werase_c;

  assign erase_c  = cfg.edit_chars[7:0];
  assign kill_c   = cfg.edit_chars[15:8];
  assign werase_c = cfg.edit_chars[23:16];

  // Strip, lowercase and CR/NL mapping in the order the discipline applies them.
  always_comb begin
    ch_strip = cfg.input_modes[0] ? (in_item.rx_char & STRIP_MASK) : in_item.rx_char;
    ch_low   = ch_strip;
    if (cfg.input_modes[1] && cfg.local_modes[2] &&
        ch_strip >= UPPER_FIRST && ch_strip <= UPPER_LAST) begin
      ch_low = ch_strip + CASE_OFFSET;
    end
    ch_map  = ch_low;
    cr_drop = 1'b0;
    if (ch_low == CHAR_CR) begin
      if (cfg.input_modes[2]) begin
        cr_drop = 1'b1;
      end else if (cfg.input_modes[3]) begin
        ch_map = CHAR_NL;
      end
    end else if (ch_low == CHAR_NL && cfg.input_modes[4]) begin
      ch_map = CHAR_CR;
    end
  end

  // Classification into one command for the executor.
  always_comb begin
    cmd.op    = CMD_APPEND;
    cmd.ch    = ch_map;
    cmd.sig   = SIG_NONE;
    cmd.count = (in_item.read_count > MaxReadC) ? MaxReadC : in_item.read_count;
    if (in_item.mode != MODE_CHAR) begin
      cmd.op = CMD_READ;
    end else if (cr_drop) begin
      cmd.op = CMD_ACK;
    end else if (cfg.local_modes[0] && ch_map == cfg.signal_chars[7:0]) begin
      cmd.op  = CMD_SIG;
      cmd.sig = SIG_INTR;
    end else if (cfg.local_modes[0] && ch_map == cfg.signal_chars[15:8]) begin
      cmd.op  = CMD_SIG;
      cmd.sig = SIG_QUIT;
    end else if (cfg.local_modes[0] && ch_map == cfg.signal_chars[23:16]) begin
      cmd.op  = CMD_SIG;
      cmd.sig = SIG_SUSP;
    end else if (ch_map == erase_c || ch_map == kill_c ||
                 (ch_map == werase_c && cfg.local_modes[2])) begin
      cmd.op = CMD_EDIT;
    end else if (ch_map == cfg.eof_key) begin
      cmd.ch = CHAR_ZERO;
    end
  end

endmodule

// File: hdl/ttyld_cmd_fifo.sv
// Two-entry command queue between the classifier and the executor.
module ttyld_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ttyld_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ttyld_pkg::cmd_t head_cmd
);
  import ttyld_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_cmd  = q_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/ttyld_back.sv
// Back end: ring buffer, line state, echo mapping and result register.
module ttyld_back #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttyld_pkg::cfg_t      cfg,
  input  logic                 cmd_valid,
  input  ttyld_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttyld_pkg::out_item_t out_data
);
  import ttyld_pkg::*;

  localparam int IdxW = $clog2(RING_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  function automatic logic [IdxW-1:0] ring_next(logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  logic [7:0]      mem [RING_DEPTH];
  logic [7:0]      rdata_r;

  back_state_t     st_r, st_nxt;
  logic [IdxW-1:0] head_r, head_nxt;
  logic [IdxW-1:0] tail_r, tail_nxt;
  logic            wait_r, wait_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            out_free;
  logic            emit_v;
  out_item_t       emit_d;
  logic            wr_en;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] tail_inc;
  logic [IdxW-1:0] head_inc;
  logic            echo_pair;
  logic [7:0]      echo_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tail_inc  = ring_next(tail_r);
  assign head_inc  = ring_next(head_r);

  // Output mapping of the echoed character.
  always_comb begin
    echo_pair = cfg.output_modes[0] && cmd.ch == CHAR_NL;
    echo_byte = cmd.ch;
    if (echo_pair) begin
      echo_byte = CHAR_CR;
    end else if (cfg.output_modes[1] && cmd.ch == CHAR_CR) begin
      echo_byte = CHAR_NL;
    end else if (cfg.output_modes[2] && cmd.ch >= LOWER_FIRST && cmd.ch <= LOWER_LAST) begin
      echo_byte = cmd.ch - CASE_OFFSET;
    end
  end

  // Command execution, one result word per cycle at most.
  always_comb begin
    st_nxt   = st_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    wait_nxt = wait_r;
    cnt_nxt  = cnt_r;
    emit_v   = 1'b0;
    emit_d   = mk_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b0, 1'b0, 1'b1);
    cmd_pop  = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head_r;
    unique case (st_r)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          emit_v  = 1'b1;
          unique case (cmd.op)
            CMD_ACK: begin
            end
            CMD_SIG: begin
              emit_d = mk_result(KIND_SIGNAL, CHAR_ZERO, cmd.sig, 1'b0, 1'b0, 1'b1);
            end
            CMD_EDIT, CMD_APPEND: begin
              if (cmd.op == CMD_APPEND && wait_r) begin
                emit_d = mk_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b1, 1'b0, 1'b1);
              end else begin
                if (cfg.local_modes[1]) begin
                  emit_d = mk_result(KIND_ECHO, echo_byte, SIG_NONE, 1'b0, 1'b0,
                                     !echo_pair);
                  if (echo_pair) begin
                    st_nxt = B_ECHO2;
                  end
                end
                if (cmd.op == CMD_EDIT) begin
                  if (tail_r != head_r) begin
                    tail_nxt = ring_prev(tail_r);
                  end
                end else begin
                  wr_en    = 1'b1;
                  tail_nxt = tail_inc;
                  if (tail_inc == head_r) begin
                    head_nxt = head_inc;
                  end
                  if (cmd.ch == CHAR_NL || cmd.ch == CHAR_ZERO) begin
                    wait_nxt = 1'b1;
                  end
                end
              end
            end
            CMD_READ: begin
              if (!wait_r) begin
                emit_d = mk_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b1, 1'b0, 1'b1);
              end else if (cmd.count == 7'd0) begin
                emit_d = mk_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b0, 1'b0, 1'b1);
              end else if (head_r == tail_r) begin
                wait_nxt = 1'b0;
                emit_d = mk_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b0, 1'b1, 1'b1);
              end else begin
                emit_v  = 1'b0;
                cnt_nxt = cmd.count;
                st_nxt  = B_RD_ADDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_ECHO2: begin
        if (out_free) begin
          emit_v = 1'b1;
          emit_d = mk_result(KIND_ECHO, CHAR_NL, SIG_NONE, 1'b0, 1'b0, 1'b1);
          st_nxt = B_IDLE;
        end
      end
      B_RD_ADDR: begin
        rd_en  = 1'b1;
        st_nxt = B_RD_OUT;
      end
      B_RD_OUT: begin
        if (out_free) begin
          emit_v   = 1'b1;
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 7'd1;
          emit_d   = mk_result(KIND_DATA, rdata_r, SIG_NONE, 1'b0, head_inc == tail_r,
                               (head_inc == tail_r) || (cnt_r == 7'd1));
          if (head_inc == tail_r) begin
            wait_nxt = 1'b0;
          end
          if ((head_inc == tail_r) || (cnt_r == 7'd1)) begin
            st_nxt = B_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_inc;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      wait_r      <= 1'b0;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      wait_r <= wait_nxt;
      cnt_r  <= cnt_nxt;
      if (out_free) begin
        out_valid_r <= emit_v;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (out_free && emit_v) begin
      out_data_r <= emit_d;
    end
  end

  // Ring memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ttyld_checker.sv
// Port-level assertions for the line discipline core and the bind that attaches them.
module ttyld_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  ttyld_pkg::out_item_t out_data
);
  import ttyld_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A refused word is a lone acknowledge.
  a_held_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.held |-> out_data.out_kind == KIND_ACK && out_data.last &&
    !out_data.drained)
    else $error("held flag on a word that is not a final acknowledge");

  // Draining the ring always ends the read.
  a_drained_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drained |-> out_data.last &&
    (out_data.out_kind == KIND_DATA || out_data.out_kind == KIND_ACK))
    else $error("drained flag on a non-final or non-read word");

  // Signal codes appear exactly on signal words, which carry no byte.
  a_signal_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.out_kind == KIND_SIGNAL) == (out_data.signal_code != SIG_NONE)) &&
    (out_data.out_kind != KIND_SIGNAL || (out_data.last && out_data.out_byte == CHAR_ZERO)))
    else $error("signal code inconsistent with result kind");

endmodule

bind canonical_tty_line_discipline_core ttyld_checker u_ttyld_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: sim/canonical_tty_line_discipline_core_tb.sv
// Self-checking testbench for the canonical terminal line discipline core.
module canonical_tty_line_discipline_core_tb;
  import ttyld_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int RING_SIZE      = 4096;
  localparam int READ_LIMIT     = 64;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 60;
  localparam int MAX_REPORTS    = 10;

  // Input word modes; only the character mode is named by the package.
  localparam logic MODE_READ = 1'b1;

  // Register indexes that decode to nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Bit positions inside the mode registers.
  localparam int IM_STRIP  = 0;
  localparam int IM_LCASE  = 1;
  localparam int IM_IGNCR  = 2;
  localparam int IM_ICRNL  = 3;
  localparam int IM_INLCR  = 4;
  localparam int LM_SIG    = 0;
  localparam int LM_ECHO   = 1;
  localparam int LM_EXT    = 2;
  localparam int OM_NLCRNL = 0;
  localparam int OM_CRNL   = 1;
  localparam int OM_UPPER  = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and expectation stores.
  in_item_t    pending_words[$];
  out_item_t   expected_words[$];

  // Line discipline image kept by the testbench.
  logic [7:0]  ring_bytes [RING_SIZE];
  int unsigned ring_head;
  int unsigned ring_tail;
  bit          line_ready;
  logic [4:0]  im_reg;
  logic [2:0]  lm_reg;
  logic [2:0]  om_reg;
  logic [23:0] sig_reg;
  logic [23:0] edit_reg;
  logic [7:0]  eof_reg;

  // Handshake bookkeeping.
  bit          in_taken;
  bit          no_idle;
  int          send_gap;
  int          stall_left;
  int          hold_request;
  int          idle_cycles;
  int          mismatches;
  int          sink_gap;
  out_item_t   want;

  canonical_tty_line_discipline_core #(
    .RING_DEPTH(RING_SIZE),
    .MAX_READ  (READ_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mismatch reporting: the first few are printed, the rest only counted.
  function automatic void note_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH: %s", msg);
    mismatches++;
  endfunction

  function automatic string show_word(out_item_t w);
    return $sformatf("kind=%0d byte=%02h sig=%0d held=%0b drained=%0b last=%0b",
                     w.out_kind, w.out_byte, w.signal_code, w.held, w.drained, w.last);
  endfunction

  // Register image of the line discipline.
  function automatic logic [31:0] reg_mask(logic [2:0] idx);
    case (idx)
      REG_INPUT_MODES:  return 32'h1F;
      REG_LOCAL_MODES:  return 32'h7;
      REG_OUTPUT_MODES: return 32'h7;
      REG_SIGNAL_CHARS: return 32'hFF_FFFF;
      REG_EDIT_CHARS:   return 32'hFF_FFFF;
      REG_EOF_CHAR:     return 32'hFF;
      default:          return 32'h0;
    endcase
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_INPUT_MODES:  im_reg   = data[4:0];
      REG_LOCAL_MODES:  lm_reg   = data[2:0];
      REG_OUTPUT_MODES: om_reg   = data[2:0];
      REG_SIGNAL_CHARS: sig_reg  = data[23:0];
      REG_EDIT_CHARS:   edit_reg = data[23:0];
      REG_EOF_CHAR:     eof_reg  = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_image(logic [2:0] idx);
    case (idx)
      REG_INPUT_MODES:  return {27'd0, im_reg};
      REG_LOCAL_MODES:  return {29'd0, lm_reg};
      REG_OUTPUT_MODES: return {29'd0, om_reg};
      REG_SIGNAL_CHARS: return {8'd0, sig_reg};
      REG_EDIT_CHARS:   return {8'd0, edit_reg};
      REG_EOF_CHAR:     return {24'd0, eof_reg};
      default:          return 32'h0;
    endcase
  endfunction

  function automatic void model_reset();
    ring_head  = 0;
    ring_tail  = 0;
    line_ready = 1'b0;
    im_reg     = RST_INPUT_MODES;
    lm_reg     = RST_LOCAL_MODES;
    om_reg     = RST_OUTPUT_MODES;
    sig_reg    = RST_SIGNAL_CHARS;
    edit_reg   = RST_EDIT_CHARS;
    eof_reg    = RST_EOF_CHAR;
  endfunction

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 == RING_SIZE) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i == 0) ? RING_SIZE - 1 : i - 1;
  endfunction

  function automatic void note_result(logic [1:0] kind, logic [7:0] b, logic [1:0] sig,
                                      logic held, logic drained);
    out_item_t w;
    w.out_kind    = kind;
    w.out_byte    = b;
    w.signal_code = sig;
    w.held        = held;
    w.drained     = drained;
    w.last        = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Echo through output mapping, when echo is enabled.
  function automatic void echo_byte(logic [7:0] c);
    if (!lm_reg[LM_ECHO]) return;
    if (om_reg[OM_NLCRNL] && c == CHAR_NL) begin
      note_result(KIND_ECHO, CHAR_CR, SIG_NONE, 1'b0, 1'b0);
      note_result(KIND_ECHO, CHAR_NL, SIG_NONE, 1'b0, 1'b0);
    end else if (om_reg[OM_CRNL] && c == CHAR_CR) begin
      note_result(KIND_ECHO, CHAR_NL, SIG_NONE, 1'b0, 1'b0);
    end else begin
      if (om_reg[OM_UPPER] && c >= LOWER_FIRST && c <= LOWER_LAST) c = c - CASE_OFFSET;
      note_result(KIND_ECHO, c, SIG_NONE, 1'b0, 1'b0);
    end
  endfunction

  // A received character: input mapping, signals, editing, then append.
  function automatic void take_char(logic [7:0] c);
    logic [1:0] sig;
    sig = SIG_NONE;
    if (im_reg[IM_STRIP]) c = c & STRIP_MASK;
    if (im_reg[IM_LCASE] && lm_reg[LM_EXT] && c >= UPPER_FIRST && c <= UPPER_LAST)
      c = c + CASE_OFFSET;
    if (c == CHAR_CR) begin
      if (im_reg[IM_IGNCR]) return;
      if (im_reg[IM_ICRNL]) c = CHAR_NL;
    end else if (c == CHAR_NL && im_reg[IM_INLCR]) begin
      c = CHAR_CR;
    end

    if (lm_reg[LM_SIG]) begin
      if (c == sig_reg[7:0]) sig = SIG_INTR;
      else if (c == sig_reg[15:8]) sig = SIG_QUIT;
      else if (c == sig_reg[23:16]) sig = SIG_SUSP;
      if (sig != SIG_NONE) begin
        note_result(KIND_SIGNAL, CHAR_ZERO, sig, 1'b0, 1'b0);
        return;
      end
    end

    // Every editing character drops just the newest byte, wrapping if needed.
    if (c == edit_reg[7:0] || c == edit_reg[15:8] ||
        (c == edit_reg[23:16] && lm_reg[LM_EXT])) begin
      if (ring_tail != ring_head) ring_tail = ring_prev(ring_tail);
      echo_byte(c);
      return;
    end

    if (c == eof_reg) c = CHAR_ZERO;

    if (line_ready) begin
      note_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b1, 1'b0);
      return;
    end

    echo_byte(c);
    ring_bytes[ring_tail] = c;
    ring_tail = ring_next(ring_tail);
    if (ring_tail == ring_head) ring_head = ring_next(ring_head);
    if (c == CHAR_NL || c == CHAR_ZERO) line_ready = 1'b1;
  endfunction

  // A read request pops bytes while a line is waiting.
  function automatic void take_read(logic [6:0] count);
    logic [7:0] b;
    int         n;
    if (!line_ready) begin
      note_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b1, 1'b0);
      return;
    end
    n = (int'(count) > READ_LIMIT) ? READ_LIMIT : int'(count);
    if (n == 0) return;
    if (ring_head == ring_tail) begin
      line_ready = 1'b0;
      note_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      b = ring_bytes[ring_head];
      ring_head = ring_next(ring_head);
      if (ring_head == ring_tail) begin
        line_ready = 1'b0;
        note_result(KIND_DATA, b, SIG_NONE, 1'b0, 1'b1);
        return;
      end
      note_result(KIND_DATA, b, SIG_NONE, 1'b0, 1'b0);
    end
  endfunction

  // Expected result words of one accepted input word; the final one is marked last.
  function automatic void predict_word(in_item_t w);
    int        n_prior;
    out_item_t tail_word;
    n_prior = expected_words.size();
    if (w.mode == MODE_CHAR) take_char(w.rx_char);
    else take_read(w.read_count);
    if (expected_words.size() == n_prior)
      note_result(KIND_ACK, CHAR_ZERO, SIG_NONE, 1'b0, 1'b0);
    tail_word = expected_words.pop_back();
    tail_word.last = 1'b1;
    expected_words.push_back(tail_word);
  endfunction

  // Stimulus builders.
  function automatic void add_char(logic [7:0] c);
    in_item_t w;
    w.mode       = MODE_CHAR;
    w.rx_char    = c;
    w.read_count = 7'($urandom());
    pending_words.push_back(w);
  endfunction

  function automatic void add_read(logic [6:0] n);
    in_item_t w;
    w.mode       = MODE_READ;
    w.rx_char    = 8'($urandom());
    w.read_count = n;
    pending_words.push_back(w);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Line content leans towards the characters the current settings treat specially.
  function automatic logic [7:0] pick_content();
    int r;
    int lane;
    r    = $urandom_range(0, 99);
    lane = $urandom_range(0, 2);
    if (r < 70) return 8'($urandom_range(0, 255));
    if (r < 78) return edit_reg[8*lane +: 8];
    if (r < 86) return sig_reg[8*lane +: 8];
    if (r < 90) return CHAR_CR;
    if (r < 94) return CHAR_NL;
    return eof_reg;
  endfunction

  function automatic logic [7:0] pick_end();
    case ($urandom_range(0, 3))
      0:       return CHAR_NL;
      1:       return CHAR_CR;
      2:       return eof_reg;
      default: return CHAR_ZERO;
    endcase
  endfunction

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(1, 16));
    if (r < 82) return 7'($urandom_range(17, 64));
    if (r < 88) return 7'(READ_LIMIT);
    if (r < 94) return 7'd0;
    return 7'($urandom_range(65, 127));
  endfunction

  // Mostly complete lines followed by reads, with some loose words mixed in.
  function automatic void gen_traffic(int n);
    int made;
    int len;
    int reps;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 75) begin
        len  = $urandom_range(0, 10);
        reps = $urandom_range(1, 3);
        repeat (len) add_char(pick_content());
        add_char(pick_end());
        repeat (reps) add_read(pick_count());
        made += len + 1 + reps;
      end else begin
        pending_words.push_back(in_item_t'(16'($urandom())));
        made++;
      end
    end
  endfunction

  // Register write with a read back; bits above a register's width carry junk.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] data;
    logic [31:0] got;
    data = ($urandom() & ~reg_mask(idx)) | (value & reg_mask(idx));
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    set_reg(idx, data);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    if (reg_mask(idx) != 0 && got !== reg_image(idx))
      note_mismatch($sformatf("register %0d reads %08h, expected %08h",
                              idx, got, reg_image(idx)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_regs(input logic [4:0] im, input logic [2:0] lm,
                              input logic [2:0] om, input logic [23:0] sc,
                              input logic [23:0] ec, input logic [7:0] ef);
    write_reg(REG_INPUT_MODES,  {27'd0, im});
    write_reg(REG_LOCAL_MODES,  {29'd0, lm});
    write_reg(REG_OUTPUT_MODES, {29'd0, om});
    write_reg(REG_SIGNAL_CHARS, {8'd0, sc});
    write_reg(REG_EDIT_CHARS,   {8'd0, ec});
    write_reg(REG_EOF_CHAR,     {24'd0, ef});
    @(posedge clk);
  endtask

  // Waits until every word has been sent and answered, then lets the core settle.
  task automatic settle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input word driver: a new word, a standing offer or a gap at each falling edge.
  always @(negedge clk) begin : word_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Offer stands until the core takes it.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_words.size() != 0) begin
      in_data  <= pending_words.pop_front();
      in_valid <= 1'b1;
      send_gap = no_idle ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin : result_sink
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      sink_gap = pick_gap();
      out_ready <= (sink_gap == 0);
      if (sink_gap > 0) stall_left = sink_gap - 1;
    end
  end

  // Monitor: predicts on accepted input words, checks result words, runs the watchdog.
  always @(posedge clk) begin : handshake_monitor
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) predict_word(in_data);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("unexpected result word: %s", show_word(out_data)));
        end else begin
          want = expected_words.pop_front();
          if (out_data !== want)
            note_mismatch($sformatf("expected %s, got %s",
                                    show_word(want), show_word(out_data)));
        end
      end
      if (in_taken || (out_valid && out_ready) || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("** canonical_tty_line_discipline_core: FAILED **");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    no_idle      = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    hold_request = 0;
    mismatches   = 0;
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: reads with no line, editing, signals, waiting lines, EOF.
    add_read(7'd0);
    add_char(8'h61);
    add_char(8'hFF);
    add_char(RST_EDIT_CHARS[7:0]);
    add_char(RST_EDIT_CHARS[15:8]);
    add_char(RST_EDIT_CHARS[23:16]);
    add_char(RST_SIGNAL_CHARS[7:0]);
    add_char(RST_SIGNAL_CHARS[15:8]);
    add_char(RST_SIGNAL_CHARS[23:16]);
    add_char(8'h78);
    add_char(8'h79);
    add_char(CHAR_CR);
    add_char(8'h7A);
    add_char(RST_SIGNAL_CHARS[7:0]);
    add_read(7'd0);
    add_read(7'd1);
    add_read(7'd127);
    add_char(8'h70);
    add_char(8'h71);
    add_char(RST_EOF_CHAR);
    repeat (4) add_char(RST_EDIT_CHARS[7:0]);
    add_read(7'(READ_LIMIT));
    settle();

    // Every input and output mapping at once.
    program_regs(5'h1F, 3'h7, 3'h7, RST_SIGNAL_CHARS, RST_EDIT_CHARS, RST_EOF_CHAR);
    add_char(8'hC1);
    add_char(CHAR_CR);
    add_char(CHAR_NL);
    add_char(8'h84);
    add_read(7'(READ_LIMIT));
    settle();

    // Random traffic under reset, cleared, full and random settings.
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin
          program_regs(RST_INPUT_MODES, RST_LOCAL_MODES, RST_OUTPUT_MODES,
                       RST_SIGNAL_CHARS, RST_EDIT_CHARS, RST_EOF_CHAR);
          write_reg(REG_SPARE_A, 32'h0);
          write_reg(REG_SPARE_B, 32'h0);
          @(posedge clk);
        end
        1: program_regs(5'h00, 3'h0, 3'h0, 24'h000000, 24'h000000, 8'h00);
        2: program_regs(5'h1F, 3'h7, 3'h7, 24'hFFFFFF, 24'hFFFFFF, 8'hFF);
        default: program_regs(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), 24'($urandom()),
                              24'($urandom()), 8'($urandom()));
      endcase
      no_idle = (k == 3);
      gen_traffic(PHASE_ITEMS);
      // Hold results back long enough for the core to fill and refuse input.
      if (k == 0) begin
        repeat (30) @(posedge clk);
        hold_request = LONG_HOLD;
      end
      settle();
    end
    no_idle = 1'b0;

    // Close any open line and drain whatever is left in the ring.
    program_regs(5'h00, 3'h0, 3'h0, RST_SIGNAL_CHARS, RST_EDIT_CHARS, RST_EOF_CHAR);
    add_char(CHAR_NL);
    repeat (((ring_tail + RING_SIZE - ring_head) % RING_SIZE) / READ_LIMIT + 2)
      add_read(7'(READ_LIMIT));
    settle();

    if (expected_words.size() != 0)
      note_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
    if (mismatches == 0) begin
      $display("** canonical_tty_line_discipline_core: PASSED **");
    end else begin
      $display("** canonical_tty_line_discipline_core: FAILED **");
    end
    $finish;
  end

endmodule
